// ===== rtl/snt_pkg.sv =====
package snt_pkg;

  // Item field widths
  localparam int VALUE_W = 10;
  localparam int COUNT_W = 4;

  // Divisor count saturates here; a sphenic number has exactly eight divisors
  localparam int COUNT_SAT        = 9;
  localparam int SPHENIC_DIVISORS = 8;

  // Shared divider: restoring steps per clock, clocks per quotient
  localparam int DIV_STEPS  = 5;
  localparam int DIV_CYCLES = VALUE_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  // Default sieve bound
  localparam int MAX_VALUE_DEF = 1024;

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_rsp_t;

endpackage

// ===== rtl/snt_divider.sv =====
// Iterative restoring divider, DIV_STEPS quotient bits per clock.
// The first batch of steps runs in the start cycle, so a new start may be
// issued in the same cycle that done is seen.
module snt_divider
  import snt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  value_t rem_r, rem_nxt;
  value_t dd_r, dd_nxt;
  value_t d_r, d_nxt;
  value_t rem_c, dd_c;

  // DIV_STEPS restoring steps on either fresh operands or the running state
  always_comb begin
    logic [VALUE_W:0] trial;
    value_t           rem_v;
    value_t           dd_v;
    d_nxt = req.start ? req.divisor : d_r;
    rem_v = req.start ? '0 : rem_r;
    dd_v  = req.start ? req.dividend : dd_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_v, dd_v[VALUE_W-1]};
      dd_v  = {dd_v[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, d_nxt}) begin
        trial   = trial - {1'b0, d_nxt};
        dd_v[0] = 1'b1;
      end
      rem_v = trial[VALUE_W-1:0];
    end
    rem_c = rem_v;
    dd_c  = dd_v;
  end

  // step counter: 1 .. DIV_CYCLES while working, done at DIV_CYCLES
  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dd_nxt  = dd_r;
    if (req.start) begin
      cnt_nxt = DIV_CNT_W'(1);
      rem_nxt = rem_c;
      dd_nxt  = dd_c;
    end else if (cnt_r == DIV_CNT_W'(DIV_CYCLES)) begin
      cnt_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      rem_nxt = rem_c;
      dd_nxt  = dd_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dd_r  <= dd_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.done      = (cnt_r == DIV_CNT_W'(DIV_CYCLES));
  assign rsp.quotient  = dd_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== rtl/sphenic_number_test_top.sv =====
// Sphenic number test. After reset the block builds a prime map over
// 0 .. MAX_VALUE-1 with a sieve of Eratosthenes and holds busy high until it
// is done: it fills the map entry by entry, then for every p with p*p below
// MAX_VALUE reads its flag and, for a prime p, strikes out its multiples. An
// item is taken when start is high and busy is low; busy then stays high
// while a nonzero item is worked on (value 0 gets its result without trial
// division). Trial division runs through the shared divider, candidates
// 1 .. value/2 and then value itself, with further checks when value has
// eight divisors. Each result appears on the out_ ports for exactly one
// cycle with out_valid high; the receiver cannot stall it, so it must take
// every result in that cycle. Prime lookups at or above MAX_VALUE count as
// not prime.
module sphenic_number_test_top
  import snt_pkg::*;
#(
  parameter int MAX_VALUE = MAX_VALUE_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  output logic               out_is_sphenic,
  output logic [COUNT_W-1:0] out_divisor_count
);

  localparam int AW   = $clog2(MAX_VALUE);
  localparam int SQ_W = AW + 2;
  localparam int PQ_W = 2 * VALUE_W;

  localparam logic [3:0] ST_FILL    = 4'd0;
  localparam logic [3:0] ST_SV_RD   = 4'd1;
  localparam logic [3:0] ST_SV_CHK  = 4'd2;
  localparam logic [3:0] ST_SV_MARK = 4'd3;
  localparam logic [3:0] ST_IDLE    = 4'd4;
  localparam logic [3:0] ST_TRY     = 4'd5;
  localparam logic [3:0] ST_CHK     = 4'd6;
  localparam logic [3:0] ST_P_CHK   = 4'd7;
  localparam logic [3:0] ST_Q_CHK   = 4'd8;
  localparam logic [3:0] ST_PQ_GO   = 4'd9;
  localparam logic [3:0] ST_PQ_DIV  = 4'd10;
  localparam logic [3:0] ST_R_CHK   = 4'd11;

  logic [3:0]         state_r, state_nxt;
  logic [AW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      p_r, p_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [AW:0]        m_r, m_nxt;
  value_t             value_r, value_nxt;
  value_t             cand_r, cand_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  value_t             div1_r, div1_nxt;
  value_t             div2_r, div2_nxt;
  logic [PQ_W-1:0]    pq_r, pq_nxt;
  logic               lk_ok_r, lk_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_sph_r, out_sph_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // prime map, one port written and one read per cycle
  logic               mem_r [MAX_VALUE];
  logic               mem_q_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               mem_wdata;
  logic [AW-1:0]      mem_raddr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic in_range(value_t idx);
    return 32'(idx) < MAX_VALUE;
  endfunction

  snt_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer: sieve after reset, then one item at a time
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    m_nxt         = m_r;
    value_nxt     = value_r;
    cand_nxt      = cand_r;
    count_nxt     = count_r;
    div1_nxt      = div1_r;
    div2_nxt      = div2_r;
    pq_nxt        = pq_r;
    lk_ok_nxt     = lk_ok_r;
    out_valid_nxt = 1'b0;
    out_sph_nxt   = out_sph_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = fill_r;
    mem_wdata     = 1'b0;
    mem_raddr     = p_r;
    div_req.start    = 1'b0;
    div_req.dividend = value_r;
    div_req.divisor  = cand_r;

    unique case (state_r)
      // map starts all prime except 0 and 1
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_r;
        mem_wdata = (fill_r >= AW'(2));
        fill_nxt  = fill_r + AW'(1);
        if (fill_r == AW'(MAX_VALUE - 1)) begin
          p_nxt     = AW'(2);
          sq_nxt    = SQ_W'(4);
          state_nxt = ST_SV_RD;
        end
      end
      ST_SV_RD: begin
        mem_raddr = p_r;
        if (32'(sq_r) >= MAX_VALUE) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SV_CHK;
        end
      end
      ST_SV_CHK: begin
        if (mem_q_r) begin
          m_nxt     = {p_r, 1'b0};
          state_nxt = ST_SV_MARK;
        end else begin
          p_nxt     = p_r + AW'(1);
          sq_nxt    = sq_r + SQ_W'({p_r, 1'b1});
          state_nxt = ST_SV_RD;
        end
      end
      // strike out multiples of p
      ST_SV_MARK: begin
        if (32'(m_r) >= MAX_VALUE) begin
          p_nxt     = p_r + AW'(1);
          sq_nxt    = sq_r + SQ_W'({p_r, 1'b1});
          state_nxt = ST_SV_RD;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = m_r[AW-1:0];
          mem_wdata = 1'b0;
          m_nxt     = m_r + (AW+1)'(p_r);
        end
      end
      ST_IDLE: begin
        if (start) begin
          value_nxt = in_value;
          count_nxt = '0;
          if (in_value == '0) begin
            out_valid_nxt = 1'b1;
            out_sph_nxt   = 1'b0;
            out_cnt_nxt   = '0;
          end else begin
            cand_nxt         = VALUE_W'(1);
            div_req.start    = 1'b1;
            div_req.dividend = in_value;
            div_req.divisor  = VALUE_W'(1);
            state_nxt        = ST_TRY;
          end
        end
      end
      // trial division: 1 .. value/2, then value
      ST_TRY: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0 && count_r < COUNT_W'(COUNT_SAT)) begin
            count_nxt = count_r + COUNT_W'(1);
            if (count_r == COUNT_W'(1)) div1_nxt = cand_r;
            if (count_r == COUNT_W'(2)) div2_nxt = cand_r;
          end
          if (cand_r == value_r) begin
            state_nxt = ST_CHK;
          end else begin
            if (cand_r >= (value_r >> 1)) begin
              cand_nxt = value_r;
            end else begin
              cand_nxt = cand_r + VALUE_W'(1);
            end
            div_req.start   = 1'b1;
            div_req.divisor = cand_nxt;
          end
        end
      end
      ST_CHK: begin
        if (count_r == COUNT_W'(SPHENIC_DIVISORS)) begin
          mem_raddr = AW'(div1_r);
          lk_ok_nxt = in_range(div1_r);
          state_nxt = ST_P_CHK;
        end else begin
          out_valid_nxt = 1'b1;
          out_sph_nxt   = 1'b0;
          out_cnt_nxt   = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_P_CHK: begin
        if (lk_ok_r && mem_q_r) begin
          mem_raddr = AW'(div2_r);
          lk_ok_nxt = in_range(div2_r);
          state_nxt = ST_Q_CHK;
        end else begin
          out_valid_nxt = 1'b1;
          out_sph_nxt   = 1'b0;
          out_cnt_nxt   = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_Q_CHK: begin
        if (lk_ok_r && mem_q_r) begin
          pq_nxt    = PQ_W'(div1_r) * PQ_W'(div2_r);
          state_nxt = ST_PQ_GO;
        end else begin
          out_valid_nxt = 1'b1;
          out_sph_nxt   = 1'b0;
          out_cnt_nxt   = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      // cofactor value / (p*q), only when p*q fits the value width
      ST_PQ_GO: begin
        if (pq_r != '0 && pq_r[PQ_W-1:VALUE_W] == '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = value_r;
          div_req.divisor  = pq_r[VALUE_W-1:0];
          state_nxt        = ST_PQ_DIV;
        end else begin
          out_valid_nxt = 1'b1;
          out_sph_nxt   = 1'b0;
          out_cnt_nxt   = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_PQ_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0 && div_rsp.quotient != div1_r &&
              div_rsp.quotient != div2_r) begin
            mem_raddr = AW'(div_rsp.quotient);
            lk_ok_nxt = in_range(div_rsp.quotient);
            state_nxt = ST_R_CHK;
          end else begin
            out_valid_nxt = 1'b1;
            out_sph_nxt   = 1'b0;
            out_cnt_nxt   = count_r;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_R_CHK: begin
        out_valid_nxt = 1'b1;
        out_sph_nxt   = lk_ok_r && mem_q_r;
        out_cnt_nxt   = count_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_FILL;
        fill_nxt  = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    sq_r      <= sq_nxt;
    m_r       <= m_nxt;
    value_r   <= value_nxt;
    cand_r    <= cand_nxt;
    count_r   <= count_nxt;
    div1_r    <= div1_nxt;
    div2_r    <= div2_nxt;
    pq_r      <= pq_nxt;
    lk_ok_r   <= lk_ok_nxt;
    out_sph_r <= out_sph_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // prime map
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem_r[mem_raddr];
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_is_sphenic    = out_sph_r;
  assign out_divisor_count = out_cnt_r;

endmodule

// ===== bench/tb_sphenic_number_test_top.sv =====
module tb_sphenic_number_test_top;
  import snt_pkg::*;

  localparam int SIEVE_BOUND  = MAX_VALUE_DEF;
  localparam int N_DIRECTED   = 23;
  localparam int N_RANDOM     = 520;
  localparam int CYCLE_LIMIT  = 2_500_000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic               is_sphenic;
    logic [COUNT_W-1:0] divisor_count;
  } sphenic_result_t;

  // one directed item; known is set where the result is typed in
  typedef struct packed {
    value_t             value;
    logic               known;
    logic               is_sphenic;
    logic [COUNT_W-1:0] divisor_count;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{10'd0,    1'b1, 1'b0, 4'd0},  // zero: no candidate tried
    '{10'd1,    1'b1, 1'b0, 4'd1},
    '{10'd2,    1'b1, 1'b0, 4'd2},
    '{10'd1023, 1'b1, 1'b1, 4'd8},  // 3*11*31, all ones
    '{10'd1001, 1'b1, 1'b1, 4'd8},  // 7*11*13
    '{10'd512,  1'b1, 1'b0, 4'd9},  // ten divisors, saturated
    '{10'd128,  1'b1, 1'b0, 4'd8},  // p^7 form
    '{10'd42,   1'b1, 1'b1, 4'd8},  // fourth divisor 6 is not prime
    '{10'd30,   1'b0, 1'b0, 4'd0},
    '{10'd24,   1'b0, 1'b0, 4'd0},  // p^3*q form
    '{10'd999,  1'b0, 1'b0, 4'd0},  // p^3*q with odd p
    '{10'd1022, 1'b0, 1'b0, 4'd0},
    '{10'd1021, 1'b0, 1'b0, 4'd0},
    '{10'd961,  1'b0, 1'b0, 4'd0},
    '{10'd720,  1'b0, 1'b0, 4'd0},
    '{10'd6,    1'b0, 1'b0, 4'd0},
    '{10'd16,   1'b0, 1'b0, 4'd0},
    '{10'd210,  1'b0, 1'b0, 4'd0},
    '{10'd3,    1'b0, 1'b0, 4'd0},
    '{10'd4,    1'b0, 1'b0, 4'd0},
    '{10'd992,  1'b0, 1'b0, 4'd0},
    '{10'd682,  1'b0, 1'b0, 4'd0},
    '{10'd341,  1'b0, 1'b0, 4'd0}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_is_sphenic;
  logic [COUNT_W-1:0] out_divisor_count;

  bit              prime_map [SIEVE_BOUND];
  sphenic_result_t sphenic_expected [$];
  int              fail_count  = 0;
  int              cycle_count = 0;

  sphenic_number_test_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_is_sphenic    (out_is_sphenic),
    .out_divisor_count (out_divisor_count)
  );

  always #4 clk = ~clk;

  // sieve of Eratosthenes over the same bound as the block
  function automatic void build_prime_map();
    for (int n = 0; n < SIEVE_BOUND; n++) prime_map[n] = 1'b1;
    prime_map[0] = 1'b0;
    prime_map[1] = 1'b0;
    for (int p = 2; p * p < SIEVE_BOUND; p++) begin
      if (prime_map[p]) begin
        for (int m = 2 * p; m < SIEVE_BOUND; m += p) prime_map[m] = 1'b0;
      end
    end
  endfunction

  function automatic bit is_prime(input int n);
    if (n < 0 || n >= SIEVE_BOUND) return 1'b0;
    return prime_map[n];
  endfunction

  // divisor count by trial division, then the three-distinct-primes check
  function automatic sphenic_result_t predict_sphenic(input value_t value);
    sphenic_result_t res;
    int              vi;
    int              cnt;
    int              kept;
    int              divs [4];
    int              pq;
    int              cof;
    vi   = int'(value);
    cnt  = 0;
    kept = 0;
    for (int k = 0; k < 4; k++) divs[k] = 0;
    for (int i = 1; i <= vi; i++) begin
      if (vi % i == 0 && cnt < COUNT_SAT) begin
        cnt++;
        if (kept < 4) begin
          divs[kept] = i;
          kept++;
        end
      end
    end
    res.is_sphenic    = 1'b0;
    res.divisor_count = cnt[COUNT_W-1:0];
    if (cnt == SPHENIC_DIVISORS && is_prime(divs[1]) && is_prime(divs[2])) begin
      pq = divs[1] * divs[2];
      if (pq != 0 && vi % pq == 0) begin
        cof = vi / pq;
        if (cof != divs[1] && cof != divs[2] && is_prime(cof)) res.is_sphenic = 1'b1;
      end
    end
    return res;
  endfunction

  // small values most often to keep items short, plus full range, eight-divisor
  // numbers and edge values
  function automatic value_t random_value();
    value_t          v;
    int              kind;
    sphenic_result_t res;
    kind = $urandom_range(99);
    if (kind < 35) begin
      v = value_t'($urandom_range(255));
    end else if (kind < 60) begin
      v = value_t'($urandom_range(1023));
    end else if (kind < 85) begin
      v = value_t'($urandom_range(1023, 30));
      for (int t = 0; t < 200; t++) begin
        res = predict_sphenic(v);
        if (res.divisor_count == SPHENIC_DIVISORS) break;
        v = value_t'($urandom_range(1023, 30));
      end
    end else begin
      case ($urandom_range(4))
        0:       v = '0;
        1:       v = '1;
        2:       v = value_t'(1) << $urandom_range(VALUE_W - 1);
        3:       v = ~(value_t'(1) << $urandom_range(VALUE_W - 1));
        default: v = value_t'($urandom_range(15));
      endcase
    end
    return v;
  endfunction

  // present one item and hold start until the block takes it
  task automatic issue_item(input value_t v, input sphenic_result_t res);
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sphenic_expected.push_back(res);
  endtask

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    sphenic_result_t exp_res;
    if (rst_n && out_valid) begin
      if (sphenic_expected.size() == 0) begin
        $error("unexpected result: is_sphenic=%0d divisor_count=%0d",
               out_is_sphenic, out_divisor_count);
        fail_count++;
      end else begin
        exp_res = sphenic_expected.pop_front();
        if (out_is_sphenic !== exp_res.is_sphenic) begin
          $error("is_sphenic: expected %0d, got %0d", exp_res.is_sphenic, out_is_sphenic);
          fail_count++;
        end
        if (out_divisor_count !== exp_res.divisor_count) begin
          $error("divisor_count: expected %0d, got %0d",
                 exp_res.divisor_count, out_divisor_count);
          fail_count++;
        end
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus: directed table, then random items, all in bursts with gaps
  initial begin
    value_t          v;
    sphenic_result_t res;
    int              burst_left;
    int              total;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    build_prime_map();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    total      = N_DIRECTED + N_RANDOM;
    burst_left = $urandom_range(12, 1);
    for (int n = 0; n < total; n++) begin
      if (n < N_DIRECTED) begin
        v = DIRECTED_ROWS[n].value;
        if (DIRECTED_ROWS[n].known) begin
          res.is_sphenic    = DIRECTED_ROWS[n].is_sphenic;
          res.divisor_count = DIRECTED_ROWS[n].divisor_count;
        end else begin
          res = predict_sphenic(v);
        end
      end else begin
        v   = random_value();
        res = predict_sphenic(v);
      end
      issue_item(v, res);

      burst_left--;
      if (n == total - 1) begin
        start <= 1'b0;
      end else if (burst_left <= 0) begin
        // gap: short ones land inside the last item's work, long ones after it
        start <= 1'b0;
        repeat ($urandom_range(40, 1)) @(posedge clk);
        burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 10)
                                               : $urandom_range(8, 1);
      end
    end

    while (sphenic_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
